@@ src/htfi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfi_pkg: shared constants and types
// Hash seed, status codes and the front-to-back request record.
// ----------------------------------------------------------------------------
package htfi_pkg;
    localparam int DEF_BUCKETS = 1024;
    localparam int DEF_WAYS    = 4;
    localparam int KEY_W       = 64;
    localparam int CFG_W       = 11;
    localparam int BIDX_W      = 10;
    localparam int SIDX_W      = 2;
    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam int KEY_BYTES   = 8;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_MISS     = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Request handed from the hash front to the probe back.
    typedef struct packed {
        logic             ins;
        logic [KEY_W-1:0] key;
        logic [15:0]      bucket;
    } req_t;
endpackage

@@ src/htfi_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfi_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module htfi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or registered read.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

@@ src/htfi_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfi_front: hash and bucket reduction
// Eight djb2 byte steps, then a restoring modulo one bit per cycle.
// ----------------------------------------------------------------------------
module htfi_front
    import htfi_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_ins,
    input  logic [KEY_W-1:0] in_key,
    input  logic [CFG_W-1:0] bucket_count,
    output logic             q_valid,
    input  logic             q_ready,
    output req_t             q_data
);
    typedef enum logic [1:0] {S_IDLE, S_HASH, S_MOD, S_OUT} state_t;

    state_t           state_reg;
    logic [5:0]       cnt_reg;
    logic [31:0]      hash_reg;
    logic [31:0]      rem_reg;
    logic [16:0]      div_reg;
    logic             ins_reg;
    logic [KEY_W-1:0] key_reg;
    logic [16:0]      eff;
    logic [7:0]       cur_byte;
    logic [32:0]      trial;

    // Effective bucket count, clamped to 1..BUCKETS.
    always_comb
    begin
        if (bucket_count == '0)
            eff = 17'd1;
        else if (32'(bucket_count) > 32'(BUCKETS))
            eff = 17'(BUCKETS);
        else
            eff = 17'(bucket_count);
    end

    assign cur_byte = key_reg[8*cnt_reg[2:0] +: 8];
    assign trial    = {rem_reg[31:0], hash_reg[31]} - {16'd0, div_reg};
    assign in_ready = (state_reg == S_IDLE);
    assign q_valid  = (state_reg == S_OUT);
    assign q_data   = '{ins: ins_reg, key: key_reg, bucket: rem_reg[15:0]};

    // Sequencer: hash steps, then 32 remainder steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        key_reg   <= in_key;
                        ins_reg   <= in_ins;
                        div_reg   <= eff;
                        hash_reg  <= HASH_SEED;
                        cnt_reg   <= '0;
                        state_reg <= S_HASH;
                    end
                S_HASH:
                begin
                    hash_reg <= (hash_reg << 5) + hash_reg + 32'(cur_byte);
                    if (cnt_reg == 6'(KEY_BYTES - 1))
                    begin
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        state_reg <= S_MOD;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_MOD:
                begin
                    if (!trial[32])
                        rem_reg <= trial[31:0];
                    else
                        rem_reg <= {rem_reg[30:0], hash_reg[31]};
                    hash_reg <= {hash_reg[30:0], 1'b0};
                    if (cnt_reg == 6'd31)
                        state_reg <= S_OUT;
                    cnt_reg <= cnt_reg + 6'd1;
                end
                S_OUT:
                    if (q_ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ src/htfi_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfi_back: bucket probe and insert
// Reads each slot of a bucket, valid bit and key together, from the key RAM,
// then reports and inserts. After reset a clearing pass marks every slot
// invalid, one slot per cycle.
// ----------------------------------------------------------------------------
module htfi_back
    import htfi_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int WAYS    = DEF_WAYS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  req_t        q_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_data
);
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int AW    = $clog2(SLOTS) > 0 ? $clog2(SLOTS) : 1;
    localparam int WW    = $clog2(WAYS) > 0 ? $clog2(WAYS) : 1;

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_CMP, S_DONE, S_OUT} state_t;

    state_t           state_reg;
    logic [AW-1:0]    clr_reg;
    req_t             req_reg;
    logic [WW:0]      way_reg;
    logic             hit_reg;
    logic             free_ok_reg;
    logic [WW-1:0]    hit_w_reg;
    logic [WW-1:0]    free_w_reg;
    logic [15:0]      out_reg;
    logic             ins_we;
    logic             we;
    logic [AW-1:0]    addr;
    logic [KEY_W:0]   wdata;
    logic [KEY_W:0]   rdata;
    logic [AW-1:0]    base;
    logic [AW-1:0]    slot_addr;
    logic [AW-1:0]    ins_addr;

    // Each RAM word holds the slot's valid bit above its key.
    assign base      = AW'(32'(req_reg.bucket) * WAYS);
    assign slot_addr = base + AW'(way_reg);
    assign ins_addr  = base + AW'(free_w_reg);
    assign ins_we    = (state_reg == S_DONE) && !hit_reg && req_reg.ins && free_ok_reg;
    assign we        = ins_we || (state_reg == S_CLR);
    assign addr      = (state_reg == S_CLR) ? clr_reg : (ins_we ? ins_addr : slot_addr);
    assign wdata     = (state_reg == S_CLR) ? '0 : {1'b1, req_reg.key};
    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;

    htfi_ram #(.WIDTH(KEY_W + 1), .DEPTH(SLOTS)) u_keys (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // Probe control: clear after reset, then read one slot, compare next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == SLOTS - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (q_valid)
                    begin
                        req_reg     <= q_data;
                        way_reg     <= '0;
                        hit_reg     <= 1'b0;
                        free_ok_reg <= 1'b0;
                        hit_w_reg   <= '0;
                        free_w_reg  <= '0;
                        state_reg   <= S_RD;
                    end
                S_RD:
                    state_reg <= S_CMP;
                S_CMP:
                begin
                    if (rdata[KEY_W])
                    begin
                        if (!hit_reg && rdata[KEY_W-1:0] == req_reg.key)
                        begin
                            hit_reg   <= 1'b1;
                            hit_w_reg <= WW'(way_reg);
                        end
                    end
                    else if (!free_ok_reg)
                    begin
                        free_ok_reg <= 1'b1;
                        free_w_reg  <= WW'(way_reg);
                    end
                    if (32'(way_reg) == WAYS - 1)
                        state_reg <= S_DONE;
                    else
                    begin
                        way_reg   <= way_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_DONE:
                begin
                    out_reg[11:2] <= req_reg.bucket[9:0];
                    if (hit_reg)
                    begin
                        out_reg[1:0]   <= ST_FOUND;
                        out_reg[15:12] <= 4'(hit_w_reg) & 4'h3;
                    end
                    else if (req_reg.ins && free_ok_reg)
                    begin
                        out_reg[1:0]   <= ST_INSERTED;
                        out_reg[15:12] <= 4'(free_w_reg) & 4'h3;
                    end
                    else
                    begin
                        out_reg[1:0]   <= req_reg.ins ? ST_FULL : ST_MISS;
                        out_reg[15:12] <= '0;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ src/hash_table_find_or_insert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_find_or_insert: bounded-chain hash table probe
// djb2 hash front, modulo reduction, bucket probe and insert back.
// ----------------------------------------------------------------------------
// Usage: s_axis carries one request per transaction (tuser = operation,
// tdata = key). m_axis returns one result per request: tdata holds status
// [1:0], bucket_index [11:2], slot_index [13:12]. bucket_count is written
// through cfg_we/cfg_wdata while no transaction is in flight.
// The front hashes an accepted request (8 hash steps) and reduces it (32
// remainder steps) before handing it over; the back then makes one
// registered key-RAM read and one compare per slot, then the insert, and
// raises m_axis_tvalid. Front and back overlap, so the sustained rate is
// set by the bit-serial remainder loop.
// Reset sets bucket_count to 1024 and starts a clearing pass that marks all
// BUCKETS*WAYS slots (4096 by default) invalid; meanwhile the front
// may accept one transaction and holds it at its handoff. If m_axis stalls,
// a result holds in the back register; the front finishes one more item and
// waits at its handoff.
// ----------------------------------------------------------------------------
module hash_table_find_or_insert
    import htfi_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int WAYS    = DEF_WAYS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,  // search_key
    input  logic             s_axis_tuser,  // operation
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata   // status, bucket_index, slot_index
);
    logic [CFG_W-1:0] bucket_count_reg;
    logic             q_valid;
    logic             q_ready;
    req_t             q_data;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bucket_count_reg <= CFG_W'(1024);
        else if (cfg_we)
            bucket_count_reg <= cfg_wdata;
    end

    htfi_front #(.BUCKETS(BUCKETS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_ins(s_axis_tuser), .in_key(s_axis_tdata),
        .bucket_count(bucket_count_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    htfi_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata)
    );
endmodule

@@ src/htfi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfi_checker: port-level checks
// Result stability under stall and field sanity.
// ----------------------------------------------------------------------------
module htfi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // Unused result bits stay zero.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:14] == 2'b00)
        else $error("result padding nonzero");

    // Miss and full report slot zero.
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[13:12] == 2'b00)
        else $error("slot nonzero on miss");

    // The front cannot accept in the cycle right after accepting.
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back-to-back accept");
endmodule

bind hash_table_find_or_insert htfi_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
